/* sv/cpp_pkg.sv */
package cpp_pkg;

    localparam int CPP_MAX_LENGTH_BYTES = 4;

    localparam logic [3:0] TYPE_CONNECT = 4'h1;

    localparam logic [4:0] SEC_HDR      = 5'd0;
    localparam logic [4:0] SEC_REMLEN   = 5'd1;
    localparam logic [4:0] SEC_PROTO    = 5'd2;
    localparam logic [4:0] SEC_VERSION  = 5'd4;
    localparam logic [4:0] SEC_FLAGS    = 5'd5;
    localparam logic [4:0] SEC_KEEPALIVE = 5'd6;
    localparam logic [4:0] SEC_FIELD1   = 5'd5;
    localparam logic [4:0] SEC_TRAIL    = 5'd17;
    localparam logic [4:0] SEC_RAW      = 5'd18;
    localparam logic [4:0] SEC_DISCARD  = 5'd19;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LENGTH  = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    typedef enum logic [11:0] {
        PH_HDR     = 12'b000000000001,
        PH_LEN     = 12'b000000000010,
        PH_VER     = 12'b000000000100,
        PH_FLAGS   = 12'b000000001000,
        PH_KA0     = 12'b000000010000,
        PH_KA1     = 12'b000000100000,
        PH_FLEN_HI = 12'b000001000000,
        PH_FLEN_LO = 12'b000010000000,
        PH_FDATA   = 12'b000100000000,
        PH_TRAIL   = 12'b001000000000,
        PH_RAW     = 12'b010000000000,
        PH_DISC    = 12'b100000000000
    } cpp_phase_t;

    typedef struct packed {
        cpp_phase_t  phase;
        logic [2:0]  field_idx;
        logic        halted;
        logic [27:0] body_left;
        logic [15:0] field_left;
        logic [27:0] length_accum;
        logic [1:0]  length_idx;
        logic [7:0]  header_bits;
        logic [2:0]  opt_flags;
    } cpp_state_t;

    typedef struct packed {
        cpp_phase_t phase;
        logic [2:0] idx;
    } cpp_next_t;

    typedef struct packed {
        logic [4:0]  section;
        logic [7:0]  byte_value;
        logic [27:0] value;
        logic        value_done;
        logic [3:0]  packet_type;
        logic        dup_flag;
        logic [1:0]  header_qos;
        logic        retain_flag;
        logic [1:0]  error_code;
        logic        packet_end;
    } cpp_result_t;

    // Selects the field that follows field f, skipping optional fields whose
    // flags are clear. Flag bit 0 is will, bit 1 user name, bit 2 password.
    function automatic cpp_next_t after_field(input logic [2:0] f, input logic [2:0] flags);
        cpp_next_t n;
        n.phase = PH_TRAIL;
        n.idx   = f;
        if (f == 3'd0)
        begin
            n.phase = PH_VER;
        end
        else if (f == 3'd1 && flags[0])
        begin
            n.phase = PH_FLEN_HI;
            n.idx   = 3'd2;
        end
        else if (f == 3'd2)
        begin
            n.phase = PH_FLEN_HI;
            n.idx   = 3'd3;
        end
        else if (f <= 3'd3 && flags[1])
        begin
            n.phase = PH_FLEN_HI;
            n.idx   = 3'd4;
        end
        else if (f <= 3'd4 && flags[2])
        begin
            n.phase = PH_FLEN_HI;
            n.idx   = 3'd5;
        end
        return n;
    endfunction

    function automatic logic [4:0] len_section(input logic [2:0] f);
        logic [4:0] s;
        if (f == 3'd0)
        begin
            s = SEC_PROTO;
        end
        else
        begin
            s = SEC_FIELD1 + {1'b0, f, 1'b0};
        end
        return s;
    endfunction

endpackage

/* sv/cpp_byte_if.sv */
interface cpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

/* sv/cpp_result_if.sv */
interface cpp_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  section;
    logic [7:0]  byte_value;
    logic [27:0] value;
    logic        value_done;
    logic [3:0]  packet_type;
    logic        dup_flag;
    logic [1:0]  header_qos;
    logic        retain_flag;
    logic [1:0]  error_code;
    logic        packet_end;

    modport source (output valid, output section, output byte_value, output value,
                    output value_done, output packet_type, output dup_flag,
                    output header_qos, output retain_flag, output error_code,
                    output packet_end, input ready);
    modport sink (input valid, input section, input byte_value, input value,
                  input value_done, input packet_type, input dup_flag,
                  input header_qos, input retain_flag, input error_code,
                  input packet_end, output ready);
endinterface

/* sv/cpp_decode.sv */
module cpp_decode
    import cpp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = CPP_MAX_LENGTH_BYTES
)
(
    input  cpp_state_t  state,
    input  logic [7:0]  data_byte,
    output cpp_state_t  state_next,
    output cpp_result_t result
);

    logic [27:0] shifted;
    logic [27:0] acc_new;
    logic [27:0] bl_dec;
    logic [15:0] len;
    logic [15:0] fl_dec;
    logic        is_connect;
    cpp_next_t   follow;
    cpp_phase_t  next_ph;
    logic [2:0]  next_idx;

    always_comb
    begin
        case (state.length_idx)
            2'd0:    shifted = {21'b0, data_byte[6:0]};
            2'd1:    shifted = {14'b0, data_byte[6:0], 7'b0};
            2'd2:    shifted = {7'b0, data_byte[6:0], 14'b0};
            2'd3:    shifted = {data_byte[6:0], 21'b0};
            default: shifted = 28'b0;
        endcase
    end

    assign acc_new    = state.length_accum | shifted;
    assign bl_dec     = (state.body_left != 28'd0) ? state.body_left - 28'd1 : 28'd0;
    assign len        = {state.field_left[15:8], data_byte};
    assign fl_dec     = state.field_left - 16'd1;
    assign is_connect = state.header_bits[7:4] == TYPE_CONNECT;
    assign follow     = after_field(state.field_idx, state.opt_flags);

    always_comb
    begin
        state_next         = state;
        next_ph            = state.phase;
        next_idx           = state.field_idx;
        result.section     = SEC_DISCARD;
        result.byte_value  = data_byte;
        result.value       = 28'd0;
        result.value_done  = 1'b0;
        result.error_code  = ERR_NONE;
        result.packet_end  = 1'b0;

        if (state.halted)
        begin
            result.error_code = ERR_LENGTH;
        end
        else
        begin
            case (state.phase)
                PH_HDR:
                begin
                    state_next.header_bits  = data_byte;
                    state_next.length_accum = 28'd0;
                    state_next.length_idx   = 2'd0;
                    state_next.phase        = PH_LEN;
                    result.section          = SEC_HDR;
                end
                PH_LEN:
                begin
                    result.section          = SEC_REMLEN;
                    state_next.length_accum = acc_new;
                    if (!data_byte[7])
                    begin
                        result.value         = acc_new;
                        result.value_done    = 1'b1;
                        state_next.body_left = acc_new;
                        if (acc_new == 28'd0)
                        begin
                            result.packet_end = 1'b1;
                            result.error_code = is_connect ? ERR_OVERRUN : ERR_NONE;
                            state_next.phase  = PH_HDR;
                        end
                        else if (is_connect)
                        begin
                            state_next.phase     = PH_FLEN_HI;
                            state_next.field_idx = 3'd0;
                        end
                        else
                        begin
                            state_next.phase = PH_RAW;
                        end
                    end
                    else if (({1'b0, state.length_idx} + 3'd1) >= 3'(MAX_LENGTH_BYTES))
                    begin
                        result.error_code = ERR_LENGTH;
                        state_next.halted = 1'b1;
                    end
                    else
                    begin
                        state_next.length_idx = state.length_idx + 2'd1;
                    end
                end
                default:
                begin
                    state_next.body_left = bl_dec;
                    case (state.phase)
                        PH_VER:
                        begin
                            result.section = SEC_VERSION;
                            next_ph        = PH_FLAGS;
                        end
                        PH_FLAGS:
                        begin
                            result.section       = SEC_FLAGS;
                            state_next.opt_flags = {data_byte[6], data_byte[7], data_byte[2]};
                            next_ph              = PH_KA0;
                        end
                        PH_KA0:
                        begin
                            result.section        = SEC_KEEPALIVE;
                            state_next.field_left = {data_byte, 8'b0};
                            next_ph               = PH_KA1;
                        end
                        PH_KA1:
                        begin
                            result.section        = SEC_KEEPALIVE;
                            result.value          = {12'b0, len};
                            result.value_done     = 1'b1;
                            state_next.field_left = 16'd0;
                            next_ph               = PH_FLEN_HI;
                            next_idx              = 3'd1;
                        end
                        PH_FLEN_HI:
                        begin
                            result.section        = len_section(state.field_idx);
                            state_next.field_left = {data_byte, 8'b0};
                            next_ph               = PH_FLEN_LO;
                        end
                        PH_FLEN_LO:
                        begin
                            result.section        = len_section(state.field_idx);
                            result.value          = {12'b0, len};
                            result.value_done     = 1'b1;
                            state_next.field_left = len;
                            if ({12'b0, len} > bl_dec)
                            begin
                                result.error_code = ERR_OVERRUN;
                                next_ph           = PH_DISC;
                            end
                            else if (len != 16'd0)
                            begin
                                next_ph = PH_FDATA;
                            end
                            else
                            begin
                                next_ph  = follow.phase;
                                next_idx = follow.idx;
                            end
                        end
                        PH_FDATA:
                        begin
                            result.section        = len_section(state.field_idx) + 5'd1;
                            state_next.field_left = fl_dec;
                            if (fl_dec == 16'd0)
                            begin
                                next_ph  = follow.phase;
                                next_idx = follow.idx;
                            end
                        end
                        PH_TRAIL:
                        begin
                            result.section = SEC_TRAIL;
                        end
                        PH_RAW:
                        begin
                            result.section = SEC_RAW;
                        end
                        default:
                        begin
                            result.section = SEC_DISCARD;
                            next_ph        = PH_DISC;
                        end
                    endcase

                    if (bl_dec == 28'd0)
                    begin
                        result.packet_end = 1'b1;
                        if (result.error_code == ERR_NONE &&
                            next_ph != PH_TRAIL && next_ph != PH_RAW && next_ph != PH_DISC)
                        begin
                            result.error_code = ERR_OVERRUN;
                        end
                        state_next.phase = PH_HDR;
                    end
                    else
                    begin
                        state_next.phase     = next_ph;
                        state_next.field_idx = next_idx;
                    end
                end
            endcase
        end

        result.packet_type = state_next.header_bits[7:4];
        result.dup_flag    = state_next.header_bits[3];
        result.header_qos  = state_next.header_bits[2:1];
        result.retain_flag = state_next.header_bits[0];
    end

endmodule

/* sv/connect_packet_parser_core.sv */
// CONNECT packet parser core.
// Packet bytes enter on byte_ch, one byte per beat, in stream order. Every
// byte gives exactly one tagged result beat on result_ch: the part of the
// packet the byte belongs to, the echoed byte, any length or keep alive value
// completed at that byte, the header fields of the current packet, an error
// code and a packet end mark.
// A byte is taken into an input register at the edge where it is accepted and
// its result is loaded into the output register once that register is free or
// its result is being taken; the output register offers it on result_ch. One
// byte is accepted per cycle while the receiver does not stall, set by the
// single parser state update per byte.
// When the receiver stalls, the result waits in the output register and one
// further byte may sit in the input register; byte_ch.ready falls only once
// both are occupied, and rises again in the cycle the result is taken.
// Reset returns the parser to the header byte of a new packet and clears the
// halt that a remaining length of more than four bytes causes; until then
// every byte is reported as discarded with the length error.
module connect_packet_parser_core
    import cpp_pkg::*;
#(
    parameter int MAX_LENGTH_BYTES = CPP_MAX_LENGTH_BYTES
)
(
    input  logic         clk,
    input  logic         rst_n,
    cpp_byte_if.sink     byte_ch,
    cpp_result_if.source result_ch
);

    cpp_state_t  state_reg;
    cpp_state_t  state_next;
    cpp_result_t result_next;
    cpp_result_t result_reg;
    logic        result_valid_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    assign advance       = !result_valid_reg || result_ch.ready;
    assign byte_ch.ready = !in_valid_reg || advance;

    cpp_decode #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_decode (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.ready && byte_ch.valid)
        begin
            in_byte_reg <= byte_ch.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_HDR;
            state_reg.field_idx    <= 3'd0;
            state_reg.halted       <= 1'b0;
            state_reg.body_left    <= 28'd0;
            state_reg.field_left   <= 16'd0;
            state_reg.length_accum <= 28'd0;
            state_reg.length_idx   <= 2'd0;
            state_reg.header_bits  <= 8'd0;
            state_reg.opt_flags    <= 3'd0;
            result_valid_reg       <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_ch.valid       = result_valid_reg;
    assign result_ch.section     = result_reg.section;
    assign result_ch.byte_value  = result_reg.byte_value;
    assign result_ch.value       = result_reg.value;
    assign result_ch.value_done  = result_reg.value_done;
    assign result_ch.packet_type = result_reg.packet_type;
    assign result_ch.dup_flag    = result_reg.dup_flag;
    assign result_ch.header_qos  = result_reg.header_qos;
    assign result_ch.retain_flag = result_reg.retain_flag;
    assign result_ch.error_code  = result_reg.error_code;
    assign result_ch.packet_end  = result_reg.packet_end;

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.halted |=> state_reg.halted)
        else $error("parser left the halted state without reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!state_reg.halted && state_reg.phase != PH_HDR && state_reg.phase != PH_LEN)
        |-> state_reg.body_left != 28'd0)
        else $error("body phase entered with no body bytes left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)
        && $stable(state_reg)))
        else $error("held byte or parser state changed during a stall");

endmodule

/* test/cpp_tag_checker.sv */
`timescale 1ns / 1ps

module cpp_tag_checker
    import cpp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cpp_byte_if   byte_ch,
    cpp_result_if result_ch,
    output int    failures,
    output int    pending,
    output int    beats_checked,
    output int    connect_packets,
    output int    overrun_errors,
    output int    halted_beats
);

    cpp_phase_t  parse_phase;
    logic [2:0]  field_idx;
    logic        halted;
    logic [27:0] body_left;
    logic [15:0] field_left;
    logic [27:0] length_accum;
    logic [1:0]  length_idx;
    logic [7:0]  header_bits;
    logic [2:0]  opt_flags;

    cpp_result_t expected_tags[$];
    cpp_result_t want;

    // Field 0 is the protocol name, 1 the client id, 2 and 3 the will topic and
    // message, 4 the user name and 5 the password.
    function automatic cpp_next_t field_after(input logic [2:0] f, input logic [2:0] flags);
        cpp_next_t n;
        logic      present;
        n.phase = PH_TRAIL;
        n.idx   = f;
        if (f == 3'd0)
        begin
            n.phase = PH_VER;
        end
        else
        begin
            for (int k = 5; k > f; k--)
            begin
                present = (k <= 3) ? flags[0] : flags[k - 3];
                if (present)
                begin
                    n.phase = PH_FLEN_HI;
                    n.idx   = 3'(k);
                end
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] length_tag(input logic [2:0] f);
        logic [4:0] s;
        if (f == 3'd0)
        begin
            s = SEC_PROTO;
        end
        else
        begin
            s = SEC_FIELD1 + 5'(2 * f);
        end
        return s;
    endfunction

    task automatic tag_byte(input logic [7:0] b, output cpp_result_t r);
        cpp_phase_t  nxt;
        logic [2:0]  nidx;
        logic [15:0] flen;
        cpp_next_t   follow;
        r            = '0;
        r.section    = SEC_DISCARD;
        r.byte_value = b;
        nxt          = parse_phase;
        nidx         = field_idx;
        if (halted)
        begin
            r.error_code = ERR_LENGTH;
        end
        else if (parse_phase == PH_HDR)
        begin
            header_bits  = b;
            r.section    = SEC_HDR;
            length_accum = '0;
            length_idx   = '0;
            parse_phase  = PH_LEN;
        end
        else if (parse_phase == PH_LEN)
        begin
            r.section    = SEC_REMLEN;
            length_accum = length_accum | ({21'd0, b[6:0]} << (7 * length_idx));
            if (!b[7])
            begin
                r.value      = length_accum;
                r.value_done = 1'b1;
                body_left    = length_accum;
                if (header_bits[7:4] == TYPE_CONNECT)
                begin
                    nxt = PH_FLEN_HI;
                end
                else
                begin
                    nxt = PH_RAW;
                end
                if (body_left == 28'd0)
                begin
                    r.packet_end = 1'b1;
                    if (nxt != PH_RAW)
                    begin
                        r.error_code = ERR_OVERRUN;
                    end
                    parse_phase = PH_HDR;
                end
                else
                begin
                    parse_phase = nxt;
                    field_idx   = 3'd0;
                end
            end
            else if (int'(length_idx) + 1 >= CPP_MAX_LENGTH_BYTES)
            begin
                r.error_code = ERR_LENGTH;
                halted       = 1'b1;
            end
            else
            begin
                length_idx = length_idx + 2'd1;
            end
        end
        else
        begin
            if (body_left != 28'd0)
            begin
                body_left = body_left - 28'd1;
            end
            case (parse_phase)
                PH_VER:
                begin
                    r.section = SEC_VERSION;
                    nxt       = PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    r.section = SEC_FLAGS;
                    opt_flags = {b[6], b[7], b[2]};
                    nxt       = PH_KA0;
                end
                PH_KA0:
                begin
                    r.section  = SEC_KEEPALIVE;
                    field_left = {b, 8'h00};
                    nxt        = PH_KA1;
                end
                PH_KA1:
                begin
                    r.section    = SEC_KEEPALIVE;
                    r.value      = {12'd0, field_left[15:8], b};
                    r.value_done = 1'b1;
                    field_left   = '0;
                    nxt          = PH_FLEN_HI;
                    nidx         = 3'd1;
                end
                PH_FLEN_HI:
                begin
                    r.section  = length_tag(field_idx);
                    field_left = {b, 8'h00};
                    nxt        = PH_FLEN_LO;
                end
                PH_FLEN_LO:
                begin
                    flen         = {field_left[15:8], b};
                    r.section    = length_tag(field_idx);
                    r.value      = {12'd0, flen};
                    r.value_done = 1'b1;
                    field_left   = flen;
                    if ({12'd0, flen} > body_left)
                    begin
                        r.error_code = ERR_OVERRUN;
                        nxt          = PH_DISC;
                    end
                    else if (flen != 16'd0)
                    begin
                        nxt = PH_FDATA;
                    end
                    else
                    begin
                        follow = field_after(field_idx, opt_flags);
                        nxt    = follow.phase;
                        nidx   = follow.idx;
                    end
                end
                PH_FDATA:
                begin
                    r.section  = length_tag(field_idx) + 5'd1;
                    field_left = field_left - 16'd1;
                    if (field_left == 16'd0)
                    begin
                        follow = field_after(field_idx, opt_flags);
                        nxt    = follow.phase;
                        nidx   = follow.idx;
                    end
                end
                PH_TRAIL:
                begin
                    r.section = SEC_TRAIL;
                end
                PH_RAW:
                begin
                    r.section = SEC_RAW;
                end
                default:
                begin
                    r.section = SEC_DISCARD;
                    nxt       = PH_DISC;
                end
            endcase
            if (body_left == 28'd0)
            begin
                r.packet_end = 1'b1;
                if (r.error_code == ERR_NONE && nxt inside {PH_VER, PH_FLAGS, PH_KA0, PH_KA1,
                                                            PH_FLEN_HI, PH_FLEN_LO, PH_FDATA})
                begin
                    r.error_code = ERR_OVERRUN;
                end
                parse_phase = PH_HDR;
            end
            else
            begin
                parse_phase = nxt;
                field_idx   = nidx;
            end
        end
        r.packet_type = header_bits[7:4];
        r.dup_flag    = header_bits[3];
        r.header_qos  = header_bits[2:1];
        r.retain_flag = header_bits[0];
    endtask

    task automatic check_field(input string label, input logic [27:0] exp_val,
                               input logic [27:0] act_val);
        if (act_val !== exp_val)
        begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, label, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase     = PH_HDR;
            field_idx       = '0;
            halted          = 1'b0;
            body_left       = '0;
            field_left      = '0;
            length_accum    = '0;
            length_idx      = '0;
            header_bits     = '0;
            opt_flags       = '0;
            expected_tags.delete();
            failures        = 0;
            pending         = 0;
            beats_checked   = 0;
            connect_packets = 0;
            overrun_errors  = 0;
            halted_beats    = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                tag_byte(byte_ch.data_byte, want);
                expected_tags.push_back(want);
                if (want.section == SEC_HDR && want.packet_type == TYPE_CONNECT)
                begin
                    connect_packets++;
                end
                if (want.error_code == ERR_OVERRUN)
                begin
                    overrun_errors++;
                end
                if (want.error_code == ERR_LENGTH && want.section == SEC_DISCARD)
                begin
                    halted_beats++;
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_tags.size() == 0)
                begin
                    failures++;
                    $display("%0t: result beat with nothing expected, section %0d byte %0d",
                             $time, result_ch.section, result_ch.byte_value);
                end
                else
                begin
                    want = expected_tags.pop_front();
                    check_field("section", want.section, result_ch.section);
                    check_field("byte_value", want.byte_value, result_ch.byte_value);
                    check_field("value", want.value, result_ch.value);
                    check_field("value_done", want.value_done, result_ch.value_done);
                    check_field("packet_type", want.packet_type, result_ch.packet_type);
                    check_field("dup_flag", want.dup_flag, result_ch.dup_flag);
                    check_field("header_qos", want.header_qos, result_ch.header_qos);
                    check_field("retain_flag", want.retain_flag, result_ch.retain_flag);
                    check_field("error_code", want.error_code, result_ch.error_code);
                    check_field("packet_end", want.packet_end, result_ch.packet_end);
                    beats_checked++;
                end
            end
            pending = expected_tags.size();
        end
    end

endmodule

/* test/connect_packet_parser_core_tb.sv */
`timescale 1ns / 1ps

module connect_packet_parser_core_tb
    import cpp_pkg::*;
();

    logic clk;
    logic rst_n;

    int failures;
    int pending;
    int beats_checked;
    int connect_packets;
    int overrun_errors;
    int halted_beats;

    logic [7:0] byte_stream[$];
    logic [7:0] pkt_body[$];

    cpp_byte_if   byte_ch();
    cpp_result_if result_ch();

    connect_packet_parser_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    cpp_tag_checker tag_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_ch         (byte_ch),
        .result_ch       (result_ch),
        .failures        (failures),
        .pending         (pending),
        .beats_checked   (beats_checked),
        .connect_packets (connect_packets),
        .overrun_errors  (overrun_errors),
        .halted_beats    (halted_beats)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic add_string(input int len);
        pkt_body.push_back(8'(len >> 8));
        pkt_body.push_back(8'(len));
        repeat (len) pkt_body.push_back(8'($urandom_range(0, 255)));
    endtask

    // The remaining length may be padded to more bytes than it needs.
    task automatic emit_packet(input logic [7:0] hdr, input int len_bytes);
        int body_len;
        int count;
        body_len = pkt_body.size();
        count    = (body_len < 128) ? 1 : (body_len < 16384) ? 2 : 3;
        if (len_bytes > count)
        begin
            count = len_bytes;
        end
        byte_stream.push_back(hdr);
        for (int i = 0; i < count; i++)
        begin
            byte_stream.push_back(8'((body_len >> (7 * i)) & 127) |
                                  ((i < count - 1) ? 8'h80 : 8'h00));
        end
        foreach (pkt_body[i])
        begin
            byte_stream.push_back(pkt_body[i]);
        end
        pkt_body.delete();
    endtask

    task automatic build_connect_body();
        logic [7:0] flags;
        pkt_body.delete();
        add_string(($urandom_range(0, 99) < 70) ? 4 : $urandom_range(0, 6));
        pkt_body.push_back(8'($urandom_range(0, 255)));
        flags = 8'($urandom_range(0, 255));
        pkt_body.push_back(flags);
        pkt_body.push_back(8'($urandom_range(0, 255)));
        pkt_body.push_back(8'($urandom_range(0, 255)));
        add_string($urandom_range(0, 8));
        if (flags[2])
        begin
            add_string($urandom_range(0, 6));
            add_string($urandom_range(0, 6));
        end
        if (flags[7])
        begin
            add_string($urandom_range(0, 6));
        end
        if (flags[6])
        begin
            add_string($urandom_range(0, 6));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 4)) pkt_body.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_stream();
        int         pick;
        int         cut;
        int         len_bytes;
        logic [3:0] ptype;
        emit_packet(8'hFF, 1);
        emit_packet({TYPE_CONNECT, 4'h0}, 1);
        pkt_body = {8'h00, 8'h00, 8'h00, 8'hC4, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        emit_packet({TYPE_CONNECT, 4'h0}, 1);
        pkt_body = {8'hFF, 8'hFF, 8'h01, 8'h02};
        emit_packet({TYPE_CONNECT, 4'h2}, 1);
        while (byte_stream.size() < 1400)
        begin
            pick      = $urandom_range(0, 99);
            len_bytes = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
            if (pick < 75)
            begin
                build_connect_body();
                if (pick >= 60)
                begin
                    cut = $urandom_range(0, pkt_body.size() - 1);
                    while (pkt_body.size() > cut)
                    begin
                        void'(pkt_body.pop_back());
                    end
                end
                emit_packet({TYPE_CONNECT, 4'($urandom_range(0, 15))}, len_bytes);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(0, 40)) pkt_body.push_back(8'($urandom_range(0, 255)));
                emit_packet({TYPE_CONNECT, 4'($urandom_range(0, 15))}, len_bytes);
            end
            else
            begin
                ptype = 4'($urandom_range(0, 15));
                if (ptype == TYPE_CONNECT)
                begin
                    ptype = 4'h0;
                end
                repeat (($urandom_range(0, 14) == 0) ? $urandom_range(128, 200)
                                                     : $urandom_range(0, 30))
                    pkt_body.push_back(8'($urandom_range(0, 255)));
                emit_packet({ptype, 4'($urandom_range(0, 15))}, len_bytes);
            end
        end
        // A remaining length that runs past four bytes halts the parser for good.
        byte_stream.push_back(8'h30);
        repeat (4) byte_stream.push_back(8'h80);
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hFF);
        repeat (3) byte_stream.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : feed_bytes
        int sent;
        bit took;
        int spin;
        sent              = 0;
        spin              = 0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        build_stream();
        wait (rst_n);
        while (sent < byte_stream.size())
        begin
            @(posedge clk);
            took = byte_ch.valid && byte_ch.ready;
            if (took)
            begin
                sent++;
            end
            if (took || !byte_ch.valid)
            begin
                if (sent < byte_stream.size() &&
                    ((sent >= 500 && sent < 750) || $urandom_range(0, 99) >= 31))
                begin
                    byte_ch.valid     <= 1'b1;
                    byte_ch.data_byte <= byte_stream[sent];
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
        while (pending != 0 && spin < 2000)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (10) @(negedge clk);
        if (pending != 0)
        begin
            $display("%0t: %0d result beats never arrived", $time, pending);
        end
        $display("Checked %0d result beats from %0d bytes: %0d CONNECT packets, %0d overruns.",
                 beats_checked, byte_stream.size(), connect_packets, overrun_errors);
        $display("Random gaps on both sides, one long receiver hold-off, %0d bytes after halt.",
                 halted_beats);
        if (failures == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin : drain_results
        int taken;
        int hold;
        bit squeezed;
        taken           = 0;
        squeezed        = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                taken++;
            end
            if (!squeezed && taken >= 1000)
            begin
                squeezed = 1'b1;
                result_ch.ready <= 1'b0;
                for (hold = 0; hold < 64; hold++)
                begin
                    @(posedge clk);
                end
            end
            else
            begin
                result_ch.ready <= (taken >= 500 && taken < 750) ||
                                   ($urandom_range(0, 99) >= 31);
            end
        end
    end

endmodule
